// File: hdl/iprh_pkg.sv
// shared types, codes and helpers for the ignition power relay hold block
// no dependencies; used by iprh_step and ignition_power_relay_hold
package iprh_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 3;

  // input opcodes
  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_CRANK      = 2'd1;
  localparam logic [1:0] OP_COMP_PULSE = 2'd2;
  localparam logic [1:0] OP_COMP_LEVEL = 2'd3;

  // sample status codes
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_NA    = 2'd1;

  // crank validity codes
  localparam logic [1:0] CV_NONE  = 2'd0;
  localparam logic [1:0] CV_UNSYN = 2'd1;

  // config register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RELAY_PRES = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEB_RISE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEB_FALL   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AFTER_IGN  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_AFTER_COMP = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_AFTER_CRK  = 3'd6;

  // mode bits
  localparam int unsigned MODE_INVERT = 0;
  localparam int unsigned MODE_COMP   = 1;
  localparam int unsigned MODE_CRANK  = 2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [TimeW-1:0] now_us;
    logic             ignition_sample;
    logic [1:0]       sample_status;
    logic             relay_write_failed;
    logic [1:0]       crank_validity;
    logic             components_level;
  } in_word_t;

  typedef struct packed {
    logic ignition_active;
    logic relay_on;
    logic relay_write;
    logic ignition_changed;
    logic components_hold;
    logic crank_hold;
    logic input_error;
    logic relay_error;
  } out_word_t;

  typedef struct packed {
    logic [2:0]       mode_bits;
    logic             relay_present;
    logic [TimeW-1:0] debounce_rise_us;
    logic [TimeW-1:0] debounce_fall_us;
    logic [TimeW-1:0] after_ignition_delay_us;
    logic [TimeW-1:0] after_components_delay_us;
    logic [TimeW-1:0] after_crank_delay_us;
  } cfg_t;

  typedef struct packed {
    logic             ign_state;
    logic [TimeW-1:0] debounce_stamp;
    logic [TimeW-1:0] ign_off_stamp;
    logic [TimeW-1:0] comp_stamp;
    logic [TimeW-1:0] crank_stamp;
    logic [2:0]       elapsed;
    logic             comp_level;
    logic             comp_pulse;
    logic             crank_running;
    logic [1:0]       trigger;
    logic             relay_last;
    logic             relay_now;
    logic [1:0]       errors;
  } state_t;

  function automatic logic reached(logic [TimeW-1:0] now, logic [TimeW-1:0] stamp,
                                   logic [TimeW-1:0] delay);
    logic [TimeW-1:0] diff;
    diff = now - stamp;
    return diff >= delay;
  endfunction

endpackage

// File: hdl/iprh_step.sv
// next-state and result logic for one word of the relay hold block
// depends on iprh_pkg
module iprh_step (
  input  iprh_pkg::cfg_t     cfg_i,
  input  iprh_pkg::state_t   state_i,
  input  iprh_pkg::in_word_t word_i,
  output iprh_pkg::state_t   state_o,
  output iprh_pkg::out_word_t result_o
);

  iprh_pkg::state_t nxt;
  logic             seen;
  logic             changed;
  logic             strobe;
  logic             trig_c;
  logic             trig_k;
  logic [iprh_pkg::TimeW-1:0] deb;

  always_comb begin
    nxt     = state_i;
    seen    = state_i.ign_state;
    changed = 1'b0;
    strobe  = 1'b0;
    trig_c  = 1'b0;
    trig_k  = 1'b0;
    deb     = cfg_i.debounce_fall_us;
    unique case (word_i.opcode)
      iprh_pkg::OP_CRANK: begin
        if (word_i.crank_validity == iprh_pkg::CV_NONE) begin
          nxt.crank_running = 1'b0;
        end else if (word_i.crank_validity != iprh_pkg::CV_UNSYN) begin
          nxt.crank_running = 1'b1;
        end
      end
      iprh_pkg::OP_COMP_PULSE: begin
        nxt.comp_pulse = 1'b1;
      end
      iprh_pkg::OP_COMP_LEVEL: begin
        nxt.comp_level = word_i.components_level;
      end
      iprh_pkg::OP_TICK: begin
        if (word_i.sample_status == iprh_pkg::ST_VALID) begin
          seen = word_i.ignition_sample ^ cfg_i.mode_bits[iprh_pkg::MODE_INVERT];
        end else if (word_i.sample_status != iprh_pkg::ST_NA) begin
          nxt.errors[0] = 1'b1;
        end

        // debounce
        deb = seen ? cfg_i.debounce_rise_us : cfg_i.debounce_fall_us;
        if (seen != state_i.ign_state) begin
          if (iprh_pkg::reached(word_i.now_us, state_i.debounce_stamp, deb)) begin
            nxt.ign_state      = seen;
            nxt.debounce_stamp = word_i.now_us;
            changed            = 1'b1;
          end
        end else begin
          nxt.debounce_stamp = word_i.now_us;
        end

        // after-ignition hold
        if (nxt.ign_state) begin
          nxt.ign_off_stamp = word_i.now_us;
          nxt.elapsed[0]    = 1'b0;
        end else if (!state_i.elapsed[0]) begin
          if (iprh_pkg::reached(word_i.now_us, state_i.ign_off_stamp,
                                cfg_i.after_ignition_delay_us)) begin
            nxt.elapsed[0] = 1'b1;
          end
        end

        // component hold
        if (cfg_i.mode_bits[iprh_pkg::MODE_COMP]) begin
          trig_c         = state_i.comp_level | state_i.comp_pulse;
          nxt.comp_pulse = 1'b0;
          if (trig_c) begin
            nxt.comp_stamp = word_i.now_us;
            nxt.elapsed[1] = 1'b0;
          end else if (!state_i.elapsed[1]) begin
            if (iprh_pkg::reached(word_i.now_us, state_i.comp_stamp,
                                  cfg_i.after_components_delay_us)) begin
              nxt.elapsed[1] = 1'b1;
            end
          end
        end else begin
          nxt.comp_stamp = word_i.now_us;
          nxt.elapsed[1] = 1'b1;
        end

        // crank hold
        if (cfg_i.mode_bits[iprh_pkg::MODE_CRANK]) begin
          trig_k = state_i.crank_running;
          if (trig_k) begin
            nxt.crank_stamp = word_i.now_us;
            nxt.elapsed[2]  = 1'b0;
          end else if (!state_i.elapsed[2]) begin
            if (iprh_pkg::reached(word_i.now_us, state_i.crank_stamp,
                                  cfg_i.after_crank_delay_us)) begin
              nxt.elapsed[2] = 1'b1;
            end
          end
        end else begin
          nxt.crank_stamp = word_i.now_us;
          nxt.elapsed[2]  = 1'b1;
        end

        nxt.trigger   = {trig_k, trig_c};
        nxt.relay_now = nxt.ign_state | trig_c | trig_k | (nxt.elapsed != 3'b111);

        // relay write strobe with retry
        if (state_i.relay_last != nxt.relay_now) begin
          if (cfg_i.relay_present) begin
            strobe = 1'b1;
            if (!word_i.relay_write_failed) begin
              nxt.relay_last = nxt.relay_now;
            end else begin
              nxt.errors[1] = 1'b1;
            end
          end else begin
            nxt.relay_last = nxt.relay_now;
          end
        end
      end
      default: ;
    endcase
  end

  assign state_o = nxt;

  assign result_o.ignition_active  = nxt.ign_state;
  assign result_o.relay_on         = nxt.relay_now;
  assign result_o.relay_write      = strobe;
  assign result_o.ignition_changed = changed;
  assign result_o.components_hold  = nxt.trigger[0];
  assign result_o.crank_hold       = nxt.trigger[1];
  assign result_o.input_error      = nxt.errors[0];
  assign result_o.relay_error      = nxt.errors[1];

endmodule

// File: hdl/ignition_power_relay_hold.sv
// top level of the ignition power relay hold block: handshakes, config and state
// depends on iprh_pkg and iprh_step
//
// Each accepted word (tick, crank validity update, component pulse or level)
// yields exactly one result word. A word is taken into an input register, its
// state update and result are computed combinationally and land in the state and
// the output register together, so one word per clock is sustained while the
// output is drained. A result held at the output stalls the word in the input
// register, and input ready drops while that register holds a word that cannot advance.
// Configuration writes take effect at once and should be made while idle.
module ignition_power_relay_hold (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  iprh_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output iprh_pkg::out_word_t                out_word_o,
  input  logic                               cfg_we_i,
  input  logic [iprh_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [iprh_pkg::TimeW-1:0]         cfg_wdata_i
);

  iprh_pkg::cfg_t      cfg_q;
  iprh_pkg::state_t    state_q;
  iprh_pkg::state_t    state_d;
  iprh_pkg::in_word_t  word_q;
  iprh_pkg::out_word_t res_d;
  iprh_pkg::out_word_t res_q;
  logic                word_valid_q;
  logic                res_valid_q;
  logic                advance;

  assign advance    = word_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !word_valid_q || advance;

  iprh_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .word_i   (word_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{relay_present: 1'b1, default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iprh_pkg::REG_MODE:       cfg_q.mode_bits                 <= cfg_wdata_i[2:0];
        iprh_pkg::REG_RELAY_PRES: cfg_q.relay_present             <= cfg_wdata_i[0];
        iprh_pkg::REG_DEB_RISE:   cfg_q.debounce_rise_us          <= cfg_wdata_i;
        iprh_pkg::REG_DEB_FALL:   cfg_q.debounce_fall_us          <= cfg_wdata_i;
        iprh_pkg::REG_AFTER_IGN:  cfg_q.after_ignition_delay_us   <= cfg_wdata_i;
        iprh_pkg::REG_AFTER_COMP: cfg_q.after_components_delay_us <= cfg_wdata_i;
        iprh_pkg::REG_AFTER_CRK:  cfg_q.after_crank_delay_us      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      word_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

  // block state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_word_o  = res_q;

endmodule
